// ===== rtl/svs_pkg.sv =====
// Shared types, constants and register indexes for the supply voltage supervisor.
`timescale 1ns / 1ps

package svs_pkg;

  // Field widths of the input and result beats.
  localparam int SUM_W      = 18;
  localparam int BAT_V_W    = 11;
  localparam int MAINS_V_W  = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int SAMPLES_W  = 7;

  // The divider takes the effective sample count as its divisor.
  localparam int DIVISOR_W  = 7;

  // Default values of the top level parameters.
  localparam int MAX_SAMPLES_DEF     = 64;
  localparam int SHORT_DEBOUNCE_DEF  = 5;
  localparam int WINDOW_DEBOUNCE_DEF = 10;
  localparam int ADC_BITS_DEF        = 12;

  // Scaling to 0.01 V units.
  localparam int BAT_MUL     = 33;
  localparam int BAT_SHIFT   = 7;
  localparam int MAINS_MUL   = 121;
  localparam int MAINS_DIV   = 125;
  localparam int MAINS_OFS   = 27;
  localparam int MAINS_MIN   = 500;

  // Division by MAINS_DIV is a multiplication by its rounded-up reciprocal.
  // It is exact for every product of a 16-bit average and MAINS_MUL.
  localparam int RECIP_W           = 24;
  localparam int MAINS_RECIP       = 8589935;
  localparam int MAINS_RECIP_SHIFT = 30;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAT_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_UPPER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LOWER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAINS_PRES   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_STOP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_START = 3'd6;

  // Register reset values.
  localparam logic [SAMPLES_W-1:0] RST_SAMPLES      = 7'd16;
  localparam logic [BAT_V_W-1:0]   RST_BAT_LOW      = 11'd350;
  localparam logic [MAINS_V_W-1:0] RST_WIN_UPPER    = 12'd2200;
  localparam logic [MAINS_V_W-1:0] RST_WIN_LOWER    = 12'd1700;
  localparam logic [MAINS_V_W-1:0] RST_MAINS_PRES   = 12'd700;
  localparam logic [BAT_V_W-1:0]   RST_CHARGE_STOP  = 11'd415;
  localparam logic [BAT_V_W-1:0]   RST_CHARGE_START = 11'd400;

  typedef struct packed {
    logic [SUM_W-1:0] battery_sum;
    logic [SUM_W-1:0] mains_sum;
    logic             system_working;
  } svs_in_t;

  typedef struct packed {
    logic [BAT_V_W-1:0]   battery_voltage;
    logic [MAINS_V_W-1:0] mains_voltage;
    logic                 battery_low;
    logic                 mains_low;
    logic                 on_battery;
    logic                 charging;
  } svs_out_t;

  typedef struct packed {
    logic [SAMPLES_W-1:0] samples_per_average;
    logic [BAT_V_W-1:0]   battery_low_level;
    logic [MAINS_V_W-1:0] mains_window_upper;
    logic [MAINS_V_W-1:0] mains_window_lower;
    logic [MAINS_V_W-1:0] mains_present_level;
    logic [BAT_V_W-1:0]   charge_stop_level;
    logic [BAT_V_W-1:0]   charge_start_level;
  } svs_cfg_t;

  typedef struct packed {
    logic battery_low;
    logic mains_low;
    logic on_battery;
    logic charging;
  } svs_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAT_DIV,
    S_MAINS_DIV,
    S_SCALE,
    S_UPDATE,
    S_LOAD
  } svs_state_t;

endpackage

// ===== rtl/svs_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module svs_div
  import svs_pkg::*;
#(
  parameter int DIV_W = 19
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic [DIV_W-1:0]     quotient,
  output logic                 done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]     work;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;
  logic [DIVISOR_W:0]   trial_sub;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    trial     = {rem, work[DIV_W-1]};
    qbit      = (trial >= {1'b0, dsr});
    trial_sub = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[DIV_W-2:0], qbit};
      rem  <= qbit ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient = work;

endmodule

// ===== rtl/svs_status.sv =====
// Debounce counters, status flags and charger hysteresis.
`timescale 1ns / 1ps

module svs_status
  import svs_pkg::*;
#(
  parameter int SHORT_DEBOUNCE  = SHORT_DEBOUNCE_DEF,
  parameter int WINDOW_DEBOUNCE = WINDOW_DEBOUNCE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic [BAT_V_W-1:0]   vbat,
  input  logic [MAINS_V_W-1:0] vraw,
  input  logic                 working,
  input  svs_cfg_t             cfg,
  output svs_flags_t           flags
);

  // Each counter stops at its limit plus one.
  localparam int SHORT_W = $clog2(SHORT_DEBOUNCE + 2);
  localparam int WIN_W   = $clog2(WINDOW_DEBOUNCE + 2);

  logic [SHORT_W-1:0] bat_low_count, bat_low_count_next;
  logic [SHORT_W-1:0] bat_ok_count, bat_ok_count_next;
  logic [WIN_W-1:0]   mains_low_count, mains_low_count_next;
  logic [SHORT_W-1:0] mains_ok_count, mains_ok_count_next;
  logic [SHORT_W-1:0] mains_on_count, mains_on_count_next;
  logic [SHORT_W-1:0] mains_off_count, mains_off_count_next;
  svs_flags_t         flags_next;

  always_comb begin
    bat_low_count_next   = bat_low_count;
    bat_ok_count_next    = bat_ok_count;
    mains_low_count_next = mains_low_count;
    mains_ok_count_next  = mains_ok_count;
    mains_on_count_next  = mains_on_count;
    mains_off_count_next = mains_off_count;
    flags_next           = flags;

    if (vbat < cfg.battery_low_level) begin
      bat_ok_count_next = '0;
      if (bat_low_count > SHORT_W'(SHORT_DEBOUNCE)) flags_next.battery_low = 1'b1;
      else bat_low_count_next = bat_low_count + SHORT_W'(1);
    end else begin
      bat_low_count_next = '0;
      if (bat_ok_count > SHORT_W'(SHORT_DEBOUNCE)) flags_next.battery_low = 1'b0;
      else bat_ok_count_next = bat_ok_count + SHORT_W'(1);
    end

    if ((vraw < cfg.mains_window_upper) && (vraw > cfg.mains_window_lower)) begin
      mains_ok_count_next = '0;
      if (mains_low_count > WIN_W'(WINDOW_DEBOUNCE)) flags_next.mains_low = 1'b1;
      else mains_low_count_next = mains_low_count + WIN_W'(1);
    end else begin
      mains_low_count_next = '0;
      if (mains_ok_count > SHORT_W'(SHORT_DEBOUNCE)) flags_next.mains_low = 1'b0;
      else mains_ok_count_next = mains_ok_count + SHORT_W'(1);
    end

    if (vraw > cfg.mains_present_level) begin
      mains_off_count_next = '0;
      if (mains_on_count > SHORT_W'(SHORT_DEBOUNCE)) flags_next.on_battery = 1'b0;
      else mains_on_count_next = mains_on_count + SHORT_W'(1);
    end else begin
      mains_on_count_next = '0;
      if (mains_off_count > SHORT_W'(SHORT_DEBOUNCE)) flags_next.on_battery = 1'b1;
      else mains_off_count_next = mains_off_count + SHORT_W'(1);
    end

    // The charger decision sees the supply flag as updated in this beat.
    if (working && !flags_next.on_battery) begin
      if (vbat > cfg.charge_stop_level) flags_next.charging = 1'b0;
      else if (vbat < cfg.charge_start_level) flags_next.charging = 1'b1;
    end else begin
      flags_next.charging = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bat_low_count   <= '0;
      bat_ok_count    <= '0;
      mains_low_count <= '0;
      mains_ok_count  <= '0;
      mains_on_count  <= '0;
      mains_off_count <= '0;
      flags           <= '0;
    end else if (update) begin
      bat_low_count   <= bat_low_count_next;
      bat_ok_count    <= bat_ok_count_next;
      mains_low_count <= mains_low_count_next;
      mains_ok_count  <= mains_ok_count_next;
      mains_on_count  <= mains_on_count_next;
      mains_off_count <= mains_off_count_next;
      flags           <= flags_next;
    end
  end

endmodule

// ===== rtl/supply_voltage_supervisor_top.sv =====
// Top level of the supply voltage supervisor: registers, sequencer and result register.
//
//   Channel  Signals                                   Direction
//   input    in_valid, in_ready, in_data (svs_in_t)    sink, one beat per second tick
//   output   out_valid, out_ready, out_data (svs_out_t) source, one beat per input beat
//   config   cfg_wr_en, cfg_wr_index, cfg_wr_data      write only, taken every cycle
//
// One input beat runs through the shared one-bit-per-cycle divider, which works out the
// two averages one after another; the mains scaling is a reciprocal multiplication in
// a state of its own. in_ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next beat is accepted while it waits.
// Reset clears the debounce counters and flags and loads the register reset values.
`timescale 1ns / 1ps

module supply_voltage_supervisor_top
  import svs_pkg::*;
#(
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
  parameter int SHORT_DEBOUNCE  = SHORT_DEBOUNCE_DEF,
  parameter int WINDOW_DEBOUNCE = WINDOW_DEBOUNCE_DEF,
  parameter int ADC_BITS        = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  svs_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output svs_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int PROD_W   = ADC_BITS + 7;
  localparam int DIV_W    = SUM_W;
  localparam int BAT_P_W  = ADC_BITS + 6;
  localparam int SCALE_W  = PROD_W + RECIP_W;
  localparam logic [DIV_W-1:0] AVG_MAX = DIV_W'((1 << ADC_BITS) - 1);

  svs_state_t            state, state_next;
  svs_cfg_t              cfg;
  svs_flags_t            flags;
  logic [SUM_W-1:0]      mains_sum;
  logic                  working;
  logic [BAT_V_W-1:0]    vbat;
  logic [MAINS_V_W-1:0]  vraw;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIV_W-1:0]      div_quot;
  logic                  div_done;

  logic [DIVISOR_W-1:0]  n_eff;
  logic [ADC_BITS-1:0]   avg_sat;
  logic [BAT_P_W-1:0]    bat_prod;
  logic [PROD_W-1:0]     mains_prod;
  logic [PROD_W-1:0]     mains_product;
  logic [SCALE_W-1:0]    scale_prod;
  logic [MAINS_V_W-1:0]  vraw_sum;
  logic                  status_upd;
  logic                  out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_average <= RST_SAMPLES;
      cfg.battery_low_level   <= RST_BAT_LOW;
      cfg.mains_window_upper  <= RST_WIN_UPPER;
      cfg.mains_window_lower  <= RST_WIN_LOWER;
      cfg.mains_present_level <= RST_MAINS_PRES;
      cfg.charge_stop_level   <= RST_CHARGE_STOP;
      cfg.charge_start_level  <= RST_CHARGE_START;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        CFG_SAMPLES:      cfg.samples_per_average <= cfg_wr_data[SAMPLES_W-1:0];
        CFG_BAT_LOW:      cfg.battery_low_level   <= cfg_wr_data[BAT_V_W-1:0];
        CFG_WIN_UPPER:    cfg.mains_window_upper  <= cfg_wr_data[MAINS_V_W-1:0];
        CFG_WIN_LOWER:    cfg.mains_window_lower  <= cfg_wr_data[MAINS_V_W-1:0];
        CFG_MAINS_PRES:   cfg.mains_present_level <= cfg_wr_data[MAINS_V_W-1:0];
        CFG_CHARGE_STOP:  cfg.charge_stop_level   <= cfg_wr_data[BAT_V_W-1:0];
        CFG_CHARGE_START: cfg.charge_start_level  <= cfg_wr_data[BAT_V_W-1:0];
        default: ;
      endcase
    end
  end

  // A sample count of zero acts as one; counts above the maximum are clamped.
  always_comb begin
    if (cfg.samples_per_average == '0) n_eff = DIVISOR_W'(1);
    else if (int'(cfg.samples_per_average) > MAX_SAMPLES) n_eff = DIVISOR_W'(MAX_SAMPLES);
    else n_eff = cfg.samples_per_average;
  end

  always_comb begin
    avg_sat    = (div_quot > AVG_MAX) ? AVG_MAX[ADC_BITS-1:0] : div_quot[ADC_BITS-1:0];
    bat_prod   = BAT_P_W'(avg_sat) * BAT_P_W'(BAT_MUL);
    mains_prod = PROD_W'(avg_sat) * PROD_W'(MAINS_MUL);
    scale_prod = SCALE_W'(mains_product) * SCALE_W'(MAINS_RECIP);
    vraw_sum   = MAINS_V_W'(scale_prod >> MAINS_RECIP_SHIFT) + MAINS_V_W'(MAINS_OFS);
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_BAT_DIV;
      S_BAT_DIV:   if (div_done) state_next = S_MAINS_DIV;
      S_MAINS_DIV: if (div_done) state_next = S_SCALE;
      S_SCALE:     state_next = S_UPDATE;
      S_UPDATE:    state_next = S_LOAD;
      S_LOAD:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(in_data.battery_sum);
    div_divisor  = n_eff;
    status_upd   = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        div_start = in_valid;
      end
      S_BAT_DIV: begin
        div_start    = div_done;
        div_dividend = DIV_W'(mains_sum);
      end
      S_MAINS_DIV, S_SCALE: ;
      S_UPDATE:    status_upd = 1'b1;
      S_LOAD:      out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Working values captured along the sequence.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      mains_sum <= in_data.mains_sum;
      working   <= in_data.system_working;
    end
    if (state == S_BAT_DIV && div_done) begin
      vbat <= BAT_V_W'(bat_prod >> BAT_SHIFT);
    end
    if (state == S_MAINS_DIV && div_done) begin
      mains_product <= mains_prod;
    end
    if (state == S_SCALE) begin
      vraw <= (vraw_sum < MAINS_V_W'(MAINS_MIN)) ? '0 : vraw_sum;
    end
  end

  svs_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  svs_status #(
    .SHORT_DEBOUNCE  (SHORT_DEBOUNCE),
    .WINDOW_DEBOUNCE (WINDOW_DEBOUNCE)
  ) u_status (
    .clk     (clk),
    .rst     (rst),
    .update  (status_upd),
    .vbat    (vbat),
    .vraw    (vraw),
    .working (working),
    .cfg     (cfg),
    .flags   (flags)
  );

  // Result register; it holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.battery_voltage <= vbat;
      out_data.mains_voltage   <= vraw;
      out_data.battery_low     <= flags.battery_low;
      out_data.mains_low       <= flags.mains_low;
      out_data.on_battery      <= flags.on_battery;
      out_data.charging        <= flags.charging;
    end
  end

endmodule

// ===== tb/tb_supply_voltage_supervisor_top.sv =====
// Self-checking testbench for the supply voltage supervisor top level.
`timescale 1ns / 1ps

module tb_supply_voltage_supervisor_top;
  import svs_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int GAP_MAX     = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int SUM_MAX     = 262080;
  localparam int ADC_MAX     = (1 << ADC_BITS_DEF) - 1;
  localparam int BAT_MASK    = (1 << BAT_V_W) - 1;
  localparam int MAINS_MASK  = (1 << MAINS_V_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  svs_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  svs_out_t              out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_wr_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  // Predictor copy of the registers, flags and debounce counters.
  svs_cfg_t   model_cfg;
  svs_flags_t model_flags;
  int         lowbat_run, okbat_run, window_run, outside_run, present_run, absent_run;

  svs_out_t   voltage_reports[$];
  svs_out_t   oldest_report;
  int         error_count = 0;
  int         tx_gap_max = GAP_MAX;
  int         rx_gap_max = GAP_MAX;
  int         rx_gap = 0;
  int         rx_hold = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         stall_cycles = 0;

  supply_voltage_supervisor_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int effective_samples();
    int n;
    n = int'(model_cfg.samples_per_average);
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_DEF) n = MAX_SAMPLES_DEF;
    return n;
  endfunction

  function automatic int average_of(logic [SUM_W-1:0] sum);
    int a;
    a = int'(sum) / effective_samples();
    if (a > ADC_MAX) a = ADC_MAX;
    return a;
  endfunction

  task automatic debounce_step(inout int own, inout int other, input int limit,
                               inout logic flag, input logic level);
    other = 0;
    if (own > limit) flag = level;
    else own++;
  endtask

  task automatic predict_report(input svs_in_t beat, output svs_out_t rep);
    int vbat;
    int vmains;
    vbat = (average_of(beat.battery_sum) * BAT_MUL / (1 << BAT_SHIFT)) & BAT_MASK;
    vmains = (average_of(beat.mains_sum) * MAINS_MUL / MAINS_DIV + MAINS_OFS) & MAINS_MASK;
    if (vmains < MAINS_MIN) vmains = 0;

    if (vbat < int'(model_cfg.battery_low_level))
      debounce_step(lowbat_run, okbat_run, SHORT_DEBOUNCE_DEF, model_flags.battery_low, 1'b1);
    else
      debounce_step(okbat_run, lowbat_run, SHORT_DEBOUNCE_DEF, model_flags.battery_low, 1'b0);

    if (vmains < int'(model_cfg.mains_window_upper) && vmains > int'(model_cfg.mains_window_lower))
      debounce_step(window_run, outside_run, WINDOW_DEBOUNCE_DEF, model_flags.mains_low, 1'b1);
    else
      debounce_step(outside_run, window_run, SHORT_DEBOUNCE_DEF, model_flags.mains_low, 1'b0);

    if (vmains > int'(model_cfg.mains_present_level))
      debounce_step(present_run, absent_run, SHORT_DEBOUNCE_DEF, model_flags.on_battery, 1'b0);
    else
      debounce_step(absent_run, present_run, SHORT_DEBOUNCE_DEF, model_flags.on_battery, 1'b1);

    // The charger follows the on_battery flag as updated by this same tick.
    if (beat.system_working && !model_flags.on_battery) begin
      if (vbat > int'(model_cfg.charge_stop_level)) model_flags.charging = 1'b0;
      else if (vbat < int'(model_cfg.charge_start_level)) model_flags.charging = 1'b1;
    end else begin
      model_flags.charging = 1'b0;
    end

    rep.battery_voltage = vbat[BAT_V_W-1:0];
    rep.mains_voltage   = vmains[MAINS_V_W-1:0];
    rep.battery_low     = model_flags.battery_low;
    rep.mains_low       = model_flags.mains_low;
    rep.on_battery      = model_flags.on_battery;
    rep.charging        = model_flags.charging;
  endtask

  // Builds a sum whose average is avg under the current sample count.
  function automatic logic [SUM_W-1:0] sum_for_average(int avg);
    int n;
    int s;
    n = effective_samples();
    if (avg < 0) avg = 0;
    if (avg >= ADC_MAX) s = $urandom_range(ADC_MAX * n, SUM_MAX);
    else s = avg * n + $urandom_range(0, n - 1);
    if (s > SUM_MAX) s = SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  function automatic int battery_average_for(int v);
    if (v < 0) v = 0;
    return (v * (1 << BAT_SHIFT) + BAT_MUL - 1) / BAT_MUL;
  endfunction

  function automatic int mains_average_for(int v);
    if (v <= MAINS_OFS) return 0;
    return ((v - MAINS_OFS) * MAINS_DIV + MAINS_MUL - 1) / MAINS_MUL;
  endfunction

  function automatic svs_in_t make_raw(int bsum, int msum, bit working);
    svs_in_t beat;
    beat.battery_sum    = bsum[SUM_W-1:0];
    beat.mains_sum      = msum[SUM_W-1:0];
    beat.system_working = working;
    return beat;
  endfunction

  function automatic svs_in_t make_tick(int vbat, int vmains, bit working);
    return make_raw(int'(sum_for_average(battery_average_for(vbat))),
                    int'(sum_for_average(mains_average_for(vmains))), working);
  endfunction

  function automatic int near(int level, int span);
    return level + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_tick(input svs_in_t beat);
    int gap;
    svs_out_t rep;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    predict_report(beat, rep);
    voltage_reports.push_back(rep);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (voltage_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= idx;
    cfg_wr_data  <= val;
    case (idx)
      CFG_SAMPLES:      model_cfg.samples_per_average = val[SAMPLES_W-1:0];
      CFG_BAT_LOW:      model_cfg.battery_low_level   = val[BAT_V_W-1:0];
      CFG_WIN_UPPER:    model_cfg.mains_window_upper  = val[MAINS_V_W-1:0];
      CFG_WIN_LOWER:    model_cfg.mains_window_lower  = val[MAINS_V_W-1:0];
      CFG_MAINS_PRES:   model_cfg.mains_present_level = val[MAINS_V_W-1:0];
      CFG_CHARGE_STOP:  model_cfg.charge_stop_level   = val[BAT_V_W-1:0];
      CFG_CHARGE_START: model_cfg.charge_start_level  = val[BAT_V_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] samples, bat_low, win_upper,
                                win_lower, mains_pres, chg_stop, chg_start);
    settle();
    write_reg(CFG_SAMPLES, samples);
    write_reg(CFG_BAT_LOW, bat_low);
    write_reg(CFG_WIN_UPPER, win_upper);
    write_reg(CFG_WIN_LOWER, win_lower);
    write_reg(CFG_MAINS_PRES, mains_pres);
    write_reg(CFG_CHARGE_STOP, chg_stop);
    write_reg(CFG_CHARGE_START, chg_start);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_defaults();
    write_settings(CFG_DATA_W'(RST_SAMPLES), CFG_DATA_W'(RST_BAT_LOW), RST_WIN_UPPER,
                   RST_WIN_LOWER, RST_MAINS_PRES, CFG_DATA_W'(RST_CHARGE_STOP),
                   CFG_DATA_W'(RST_CHARGE_START));
  endtask

  // Default thresholds with only the sample count changed.
  task automatic write_samples(input logic [CFG_DATA_W-1:0] samples);
    write_settings(samples, CFG_DATA_W'(RST_BAT_LOW), RST_WIN_UPPER, RST_WIN_LOWER,
                   RST_MAINS_PRES, CFG_DATA_W'(RST_CHARGE_STOP),
                   CFG_DATA_W'(RST_CHARGE_START));
  endtask

  function automatic int pick_battery_target();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1100);
      1:       return near(int'(model_cfg.battery_low_level), 3);
      2:       return near(int'(model_cfg.charge_start_level), 3);
      default: return near(int'(model_cfg.charge_stop_level), 3);
    endcase
  endfunction

  function automatic int pick_mains_target();
    int lo;
    int hi;
    lo = int'(model_cfg.mains_window_lower);
    hi = int'(model_cfg.mains_window_upper);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 520);
      1: begin
        if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
        return $urandom_range(0, 4000);
      end
      2: return near(int'(model_cfg.mains_present_level), 3);
      3: return ($urandom_range(0, 1) != 0) ? near(hi, 2) : near(lo, 2);
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  // Runs of ticks with steady supply levels let the debounce counters saturate;
  // a tenth of the ticks are unrelated noise.
  task automatic run_random(input int count);
    int left;
    int run_len;
    int vb;
    int vm;
    int k;
    bit working;
    left = count;
    while (left > 0) begin
      run_len    = $urandom_range(1, 16);
      tx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : GAP_MAX;
      rx_gap_max = ($urandom_range(0, 4) == 0) ? 0 : GAP_MAX;
      vb         = pick_battery_target();
      vm         = pick_mains_target();
      working    = ($urandom_range(0, 3) != 0);
      for (k = 0; k < run_len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_tick(make_raw($urandom_range(0, SUM_MAX), $urandom_range(0, SUM_MAX),
                             1'($urandom_range(0, 1))));
        else
          send_tick(make_tick(near(vb, 2), near(vm, 2), working));
        left--;
      end
    end
  endtask

  task automatic test_field_extremes();
    send_tick(make_raw(0, 0, 1'b0));
    send_tick(make_raw(SUM_MAX, SUM_MAX, 1'b1));
    send_tick(make_raw('h2AAAA, 'h15555, 1'b1));
    send_tick(make_raw('h15555, 'h2AAAA, 1'b0));
    // Averages of 488 and 489 scale to 499 V*100 (forced to zero) and exactly 500.
    send_tick(make_raw(0, 488 * RST_SAMPLES, 1'b1));
    send_tick(make_raw(ADC_MAX * RST_SAMPLES, 489 * RST_SAMPLES, 1'b1));
  endtask

  task automatic test_sample_count();
    // Zero is used as one, and counts above the maximum are clipped to it;
    // the last write has only bits above the register width set.
    write_samples(CFG_DATA_W'(0));
    send_tick(make_raw(3000, 60000, 1'b1));
    write_samples(CFG_DATA_W'(1));
    send_tick(make_raw(3000, 60000, 1'b1));
    write_samples(CFG_DATA_W'(MAX_SAMPLES_DEF));
    send_tick(make_raw(SUM_MAX, 60000, 1'b1));
    write_samples(CFG_DATA_W'(127));
    send_tick(make_raw(SUM_MAX, 60000, 1'b1));
    write_samples(CFG_DATA_W'('hF80));
    send_tick(make_raw(3000, 60000, 1'b0));
  endtask

  task automatic test_debounce();
    // Long enough for both the short and the window debounce to flip their flags.
    write_defaults();
    repeat (12) send_tick(make_tick(300, 2000, 1'b1));
  endtask

  task automatic test_charge_hysteresis();
    send_tick(make_tick(410, 2500, 1'b1));
    send_tick(make_tick(420, 2500, 1'b1));
    send_tick(make_tick(410, 2500, 1'b1));
    send_tick(make_tick(390, 2500, 1'b1));
    send_tick(make_tick(390, 2500, 1'b0));
  endtask

  task automatic test_output_backpressure();
    hold_requests++;
    run_random(24);
  endtask

  task automatic test_random_settings();
    write_defaults();
    run_random(70);
    write_settings(1, 0, 0, 0, 0, 0, 0);
    run_random(70);
    write_settings(CFG_DATA_W'(MAX_SAMPLES_DEF), 1055, 3991, 0, 3991, 1055, 1055);
    run_random(70);
    write_settings('hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF, 'hFFF);
    run_random(70);
    // Start level above stop level: charging toggles without a hold band.
    write_settings(8, 500, 3000, 1000, 600, 300, 700);
    run_random(70);
    write_settings(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(0, 1055)),
                   CFG_DATA_W'($urandom_range(0, 3991)), CFG_DATA_W'($urandom_range(0, 3991)),
                   CFG_DATA_W'($urandom_range(0, 3991)), CFG_DATA_W'($urandom_range(0, 1055)),
                   CFG_DATA_W'($urandom_range(0, 1055)));
    run_random(70);
  endtask

  // Result side: checks each accepted beat and stalls ready between beats.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (voltage_reports.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          error_count++;
        end else begin
          oldest_report = voltage_reports.pop_front();
          if (out_data.battery_voltage !== oldest_report.battery_voltage) begin
            $error("battery_voltage: expected %0d, got %0d",
                   oldest_report.battery_voltage, out_data.battery_voltage);
            error_count++;
          end
          if (out_data.mains_voltage !== oldest_report.mains_voltage) begin
            $error("mains_voltage: expected %0d, got %0d",
                   oldest_report.mains_voltage, out_data.mains_voltage);
            error_count++;
          end
          if (out_data.battery_low !== oldest_report.battery_low) begin
            $error("battery_low: expected %0d, got %0d",
                   oldest_report.battery_low, out_data.battery_low);
            error_count++;
          end
          if (out_data.mains_low !== oldest_report.mains_low) begin
            $error("mains_low: expected %0d, got %0d",
                   oldest_report.mains_low, out_data.mains_low);
            error_count++;
          end
          if (out_data.on_battery !== oldest_report.on_battery) begin
            $error("on_battery: expected %0d, got %0d",
                   oldest_report.on_battery, out_data.on_battery);
            error_count++;
          end
          if (out_data.charging !== oldest_report.charging) begin
            $error("charging: expected %0d, got %0d",
                   oldest_report.charging, out_data.charging);
            error_count++;
          end
        end
        rx_gap = $urandom_range(0, rx_gap_max);
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        rx_hold = HOLD_CYCLES;
      end
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("supply_voltage_supervisor_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_index = CFG_SAMPLES;
    cfg_wr_data  = '0;
    model_cfg.samples_per_average = RST_SAMPLES;
    model_cfg.battery_low_level   = RST_BAT_LOW;
    model_cfg.mains_window_upper  = RST_WIN_UPPER;
    model_cfg.mains_window_lower  = RST_WIN_LOWER;
    model_cfg.mains_present_level = RST_MAINS_PRES;
    model_cfg.charge_stop_level   = RST_CHARGE_STOP;
    model_cfg.charge_start_level  = RST_CHARGE_START;
    model_flags = '0;
    lowbat_run  = 0;
    okbat_run   = 0;
    window_run  = 0;
    outside_run = 0;
    present_run = 0;
    absent_run  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_sample_count();
    test_debounce();
    test_charge_hysteresis();
    test_output_backpressure();
    test_random_settings();

    settle();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("supply_voltage_supervisor_top regression: pass");
    end else begin
      $display("supply_voltage_supervisor_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/svs_pkg.sv
rtl/svs_div.sv
rtl/svs_status.sv
rtl/supply_voltage_supervisor_top.sv
tb/tb_supply_voltage_supervisor_top.sv
